// ===== src/euv_pkg.sv =====
package euv_pkg;

  // angles are in 1/256 degree
  localparam int HALF_TURN    = 180 * 256;
  localparam int FULL_TURN    = 2 * HALF_TURN;
  localparam int QUARTER_TURN = HALF_TURN / 2;
  localparam int EIGHTH_TURN  = HALF_TURN / 4;

  // round(pi * 2^46 / 46080): angle units to radians in Q46
  localparam logic [32:0] ANG_TO_RAD = 33'd4797524517;

  localparam int HORNER_STEPS = 6;
  localparam logic [7:0] SIN_DIV [HORNER_STEPS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [7:0] COS_DIV [HORNER_STEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

  // pipeline depths of the sine/cosine unit and of one plane rotation
  localparam int SC_LAT  = 24;
  localparam int ROT_LAT = 2;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  typedef struct packed {
    axis_t axis;
    logic  neg;
  } rot_ctl_t;

endpackage

// ===== src/euv_delay.sv =====
module euv_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] sr_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign q = sr_r[DEPTH-1];

endmodule

// ===== src/euv_sincos.sv =====
module euv_sincos #(
  parameter int AW = 20,
  parameter int T  = 30
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [AW-1:0] angle,
  output logic signed [T+1:0]  sin_o,
  output logic signed [T+1:0]  cos_o
);

  import euv_pkg::*;

  localparam longint unsigned HALF_RANGE = 64'd1 << (AW - 1);
  localparam longint unsigned OFFSET =
    ((HALF_RANGE + FULL_TURN - 1) / FULL_TURN) * FULL_TURN;
  localparam int UW = $clog2(OFFSET + HALF_RANGE);
  localparam int QW = UW - 16;
  localparam longint unsigned RECIP = (64'd1 << UW) / FULL_TURN;
  localparam int RW  = $clog2(FULL_TURN);
  localparam int AQW = $clog2(QUARTER_TURN);
  localparam int BW  = $clog2(EIGHTH_TURN + 1);
  localparam int SH  = 30 - T;
  localparam int RND = (1 << SH) >> 1;
  localparam logic [30:0] Q30_ONE = 31'd1 << 30;

  // stage 0: offset to nonnegative, estimate turns
  logic [UW-1:0] u;
  logic [UW-1:0] u0_r;
  logic [QW-1:0] qe0_r;

  assign u = UW'(angle) + UW'(OFFSET);

  always_ff @(posedge clk) begin
    if (en) begin
      u0_r  <= u;
      qe0_r <= QW'(((UW+QW)'(u) * (UW+QW)'(RECIP)) >> UW);
    end
  end

  // stage 1: fix remainder, fold into first octant
  logic [UW-1:0]  r_raw;
  logic [RW-1:0]  r_mod;
  logic [1:0]     quad;
  logic [AQW-1:0] a_q;
  logic           swap_c;
  logic [BW-1:0]  b_c;
  logic [BW-1:0]  a1_r;
  logic [1:0]     quad1_r;
  logic           swap1_r;

  always_comb begin
    r_raw = u0_r - UW'(qe0_r) * UW'(FULL_TURN);
    if (r_raw >= UW'(FULL_TURN)) begin
      r_mod = RW'(r_raw - UW'(FULL_TURN));
    end else begin
      r_mod = RW'(r_raw);
    end
    if (r_mod >= RW'(3 * QUARTER_TURN)) begin
      quad = 2'd3;
      a_q  = AQW'(r_mod - RW'(3 * QUARTER_TURN));
    end else if (r_mod >= RW'(2 * QUARTER_TURN)) begin
      quad = 2'd2;
      a_q  = AQW'(r_mod - RW'(2 * QUARTER_TURN));
    end else if (r_mod >= RW'(QUARTER_TURN)) begin
      quad = 2'd1;
      a_q  = AQW'(r_mod - RW'(QUARTER_TURN));
    end else begin
      quad = 2'd0;
      a_q  = AQW'(r_mod);
    end
    swap_c = a_q > AQW'(EIGHTH_TURN);
    b_c    = swap_c ? BW'(AQW'(QUARTER_TURN) - a_q) : BW'(a_q);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r    <= b_c;
      quad1_r <= quad;
      swap1_r <= swap_c;
    end
  end

  // stages 2 and 3: radians in Q30, then its square
  logic [29:0] x_s2_r;
  logic [29:0] x_s3_r;
  logic [29:0] xsq_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x_s2_r <= 30'((47'(a1_r) * 47'(ANG_TO_RAD) + 47'(1 << 15)) >> 16);
      x_s3_r <= x_s2_r;
      xsq_r  <= 30'((60'(x_s2_r) * 60'(x_s2_r)) >> 30);
    end
  end

  // Horner steps, three stages each: product, reciprocal estimate, correction
  logic [29:0] x2_c_r [HORNER_STEPS];
  logic [30:0] hs_c_r [HORNER_STEPS];
  logic [30:0] hc_c_r [HORNER_STEPS];

  for (genvar g = 0; g < HORNER_STEPS; g++) begin : g_step
    localparam logic [29:0] KS = 30'(SIN_DIV[g]);
    localparam logic [29:0] KC = 30'(COS_DIV[g]);
    localparam logic [29:0] MS = 30'((64'd1 << 30) / SIN_DIV[g]);
    localparam logic [29:0] MC = 30'((64'd1 << 30) / COS_DIV[g]);

    logic [29:0] x2_in;
    logic [30:0] hs_in;
    logic [30:0] hc_in;
    logic [29:0] x2_a_r, x2_b_r;
    logic [29:0] ns_a_r, nc_a_r, ns_b_r, nc_b_r;
    logic [29:0] qs_b_r, qc_b_r;
    logic [29:0] rs, rc;
    logic [29:0] qs_fix, qc_fix;

    if (g == 0) begin : g_first
      assign x2_in = xsq_r;
      assign hs_in = Q30_ONE;
      assign hc_in = Q30_ONE;
    end else begin : g_next
      assign x2_in = x2_c_r[g-1];
      assign hs_in = hs_c_r[g-1];
      assign hc_in = hc_c_r[g-1];
    end

    always_comb begin
      rs     = ns_b_r - 30'(qs_b_r * KS);
      rc     = nc_b_r - 30'(qc_b_r * KC);
      qs_fix = qs_b_r + 30'(rs >= KS);
      qc_fix = qc_b_r + 30'(rc >= KC);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x2_a_r    <= x2_in;
        ns_a_r    <= 30'((61'(x2_in) * 61'(hs_in)) >> 30);
        nc_a_r    <= 30'((61'(x2_in) * 61'(hc_in)) >> 30);
        x2_b_r    <= x2_a_r;
        ns_b_r    <= ns_a_r;
        nc_b_r    <= nc_a_r;
        qs_b_r    <= 30'((60'(ns_a_r) * 60'(MS)) >> 30);
        qc_b_r    <= 30'((60'(nc_a_r) * 60'(MC)) >> 30);
        x2_c_r[g] <= x2_b_r;
        hs_c_r[g] <= Q30_ONE - 31'(qs_fix);
        hc_c_r[g] <= Q30_ONE - 31'(qc_fix);
      end
    end
  end

  logic [29:0] x_d;
  logic [2:0]  qs_d;

  euv_delay #(.WIDTH(30), .DEPTH(3 * HORNER_STEPS)) u_x_dly (
    .clk (clk),
    .en  (en),
    .d   (x_s3_r),
    .q   (x_d)
  );

  euv_delay #(.WIDTH(3), .DEPTH(3 * HORNER_STEPS + 3)) u_q_dly (
    .clk (clk),
    .en  (en),
    .d   ({swap1_r, quad1_r}),
    .q   (qs_d)
  );

  // sine magnitude, then rounding and quadrant signs
  logic [29:0] sm_r;
  logic [30:0] cm_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sm_r <= 30'((61'(x_d) * 61'(hs_c_r[HORNER_STEPS-1])) >> 30);
      cm_r <= hc_c_r[HORNER_STEPS-1];
    end
  end

  logic [30:0]        smag, cmag;
  logic [T:0]         sr, cr;
  logic signed [T+1:0] sp, cp;
  logic signed [T+1:0] sin_r, cos_r;

  always_comb begin
    smag = qs_d[2] ? cm_r : {1'b0, sm_r};
    cmag = qs_d[2] ? {1'b0, sm_r} : cm_r;
    sr   = (T+1)'((smag + 31'(RND)) >> SH);
    cr   = (T+1)'((cmag + 31'(RND)) >> SH);
    sp   = $signed({1'b0, sr});
    cp   = $signed({1'b0, cr});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (qs_d[1:0])
        2'd0: begin
          sin_r <= sp;
          cos_r <= cp;
        end
        2'd1: begin
          sin_r <= cp;
          cos_r <= -sp;
        end
        2'd2: begin
          sin_r <= -sp;
          cos_r <= -cp;
        end
        default: begin
          sin_r <= -cp;
          cos_r <= sp;
        end
      endcase
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

// ===== src/euv_plane_rot.sv =====
module euv_plane_rot #(
  parameter int VW = 34,
  parameter int T  = 30
) (
  input  logic                clk,
  input  logic                en,
  input  euv_pkg::rot_ctl_t   ctl_i,
  input  logic signed [T+1:0] sin_i,
  input  logic signed [T+1:0] cos_i,
  input  logic signed [VW-1:0] x_i,
  input  logic signed [VW-1:0] y_i,
  input  logic signed [VW-1:0] z_i,
  output logic signed [VW-1:0] x_o,
  output logic signed [VW-1:0] y_o,
  output logic signed [VW-1:0] z_o
);

  import euv_pkg::*;

  localparam int TW = T + 2;
  localparam int PW = VW + TW;
  localparam logic signed [PW:0] RNDR = {{(PW-T+1){1'b0}}, 1'b1, {(T-1){1'b0}}};

  logic signed [VW-1:0] u, w, p;
  logic signed [TW-1:0] s;

  always_comb begin
    s = ctl_i.neg ? -sin_i : sin_i;
    unique case (ctl_i.axis)
      AXIS_X: begin
        u = y_i;
        w = z_i;
        p = x_i;
      end
      AXIS_Y: begin
        u = z_i;
        w = x_i;
        p = y_i;
      end
      default: begin
        u = x_i;
        w = y_i;
        p = z_i;
      end
    endcase
  end

  logic signed [PW-1:0] uc_r, ws_r, us_r, wc_r;
  logic signed [VW-1:0] pass_r;
  axis_t                axis_r;

  always_ff @(posedge clk) begin
    if (en) begin
      uc_r   <= PW'(u) * PW'(cos_i);
      ws_r   <= PW'(w) * PW'(s);
      us_r   <= PW'(u) * PW'(s);
      wc_r   <= PW'(w) * PW'(cos_i);
      pass_r <= p;
      axis_r <= ctl_i.axis;
    end
  end

  logic signed [PW:0]   sum_u, sum_w;
  logic signed [VW-1:0] nu, nw;
  logic signed [VW-1:0] x_r, y_r, z_r;

  always_comb begin
    sum_u = (PW+1)'(uc_r) - (PW+1)'(ws_r) + RNDR;
    sum_w = (PW+1)'(us_r) + (PW+1)'(wc_r) + RNDR;
    nu    = VW'(sum_u >>> T);
    nw    = VW'(sum_w >>> T);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unique case (axis_r)
        AXIS_X: begin
          x_r <= pass_r;
          y_r <= nu;
          z_r <= nw;
        end
        AXIS_Y: begin
          x_r <= nw;
          y_r <= pass_r;
          z_r <= nu;
        end
        default: begin
          x_r <= nu;
          y_r <= nw;
          z_r <= pass_r;
        end
      endcase
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

// ===== src/euler_vector_rotation.sv =====
// Throughput: one request per cycle; the sine/cosine units and the three
// plane rotations are fully pipelined, and a stall on out_tready freezes
// the whole pipeline.
// Reset: synchronous, active low; clears the valid flags only.
module euler_vector_rotation #(
  parameter int COORD_WIDTH    = 32,
  parameter int ANGLE_WIDTH    = 20,
  parameter int TRIG_FRAC_BITS = 30
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // vec_x, vec_y, vec_z, roll_angle, pitch_angle, yaw_angle, zero fill
  input  logic [((3*COORD_WIDTH+3*ANGLE_WIDTH+7)/8)*8-1:0] in_tdata,
  // cmd
  input  logic [0:0] in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // rot_x, rot_y, rot_z, zero fill
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0] out_tdata,
  // saturated
  output logic [0:0] out_tuser
);

  import euv_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int AW  = ANGLE_WIDTH;
  localparam int T   = TRIG_FRAC_BITS;
  localparam int TW  = T + 2;
  localparam int VW  = CW + 2;
  localparam int ODW = ((3 * CW + 7) / 8) * 8;
  localparam int NV  = SC_LAT + 3 * ROT_LAT;
  localparam logic signed [TW-1:0] TRIG_ONE = TW'(1) << T;

  logic en;
  assign en        = ~out_tvalid | out_tready;
  assign in_tready = en;

  logic signed [AW-1:0] roll_a, pitch_a, yaw_a;
  assign roll_a  = in_tdata[3*CW+AW-1:3*CW];
  assign pitch_a = in_tdata[3*CW+2*AW-1:3*CW+AW];
  assign yaw_a   = in_tdata[3*CW+3*AW-1:3*CW+2*AW];

  logic signed [TW-1:0] roll_s, roll_c, pitch_s, pitch_c, yaw_s, yaw_c;

  euv_sincos #(.AW(AW), .T(T)) u_roll (
    .clk (clk), .en (en), .angle (roll_a), .sin_o (roll_s), .cos_o (roll_c)
  );

  euv_sincos #(.AW(AW), .T(T)) u_pitch (
    .clk (clk), .en (en), .angle (pitch_a), .sin_o (pitch_s), .cos_o (pitch_c)
  );

  euv_sincos #(.AW(AW), .T(T)) u_yaw (
    .clk (clk), .en (en), .angle (yaw_a), .sin_o (yaw_s), .cos_o (yaw_c)
  );

  // hold the vector and cmd alongside the trig pipeline
  logic [3*CW:0] dv;

  euv_delay #(.WIDTH(3*CW+1), .DEPTH(SC_LAT)) u_vec_dly (
    .clk (clk),
    .en  (en),
    .d   ({in_tuser[0], in_tdata[3*CW-1:0]}),
    .q   (dv)
  );

  logic cmd1;
  assign cmd1 = dv[3*CW];

  // forward: z, y, x axes in turn; inverse: x, y, z with negated angles
  rot_ctl_t ctl1, ctl2, ctl3;
  logic signed [TW-1:0] s1, c1, s2, c2, s3, c3, t3s, t3c;
  logic cmd2, cmd3;

  assign s1  = cmd1 ? roll_s : yaw_s;
  assign c1  = cmd1 ? roll_c : yaw_c;
  assign t3s = cmd1 ? yaw_s : roll_s;
  assign t3c = cmd1 ? yaw_c : roll_c;

  euv_delay #(.WIDTH(2*TW+1), .DEPTH(ROT_LAT)) u_t2_dly (
    .clk (clk),
    .en  (en),
    .d   ({cmd1, pitch_s, pitch_c}),
    .q   ({cmd2, s2, c2})
  );

  euv_delay #(.WIDTH(2*TW+1), .DEPTH(2*ROT_LAT)) u_t3_dly (
    .clk (clk),
    .en  (en),
    .d   ({cmd1, t3s, t3c}),
    .q   ({cmd3, s3, c3})
  );

  assign ctl1 = '{axis: (cmd1 ? AXIS_X : AXIS_Z), neg: cmd1};
  assign ctl2 = '{axis: AXIS_Y, neg: cmd2};
  assign ctl3 = '{axis: (cmd3 ? AXIS_Z : AXIS_X), neg: cmd3};

  logic signed [VW-1:0] x0, y0, z0, x1, y1, z1, x2, y2, z2, x3, y3, z3;

  assign x0 = VW'($signed(dv[CW-1:0]));
  assign y0 = VW'($signed(dv[2*CW-1:CW]));
  assign z0 = VW'($signed(dv[3*CW-1:2*CW]));

  euv_plane_rot #(.VW(VW), .T(T)) u_rot1 (
    .clk (clk), .en (en), .ctl_i (ctl1), .sin_i (s1), .cos_i (c1),
    .x_i (x0), .y_i (y0), .z_i (z0), .x_o (x1), .y_o (y1), .z_o (z1)
  );

  euv_plane_rot #(.VW(VW), .T(T)) u_rot2 (
    .clk (clk), .en (en), .ctl_i (ctl2), .sin_i (s2), .cos_i (c2),
    .x_i (x1), .y_i (y1), .z_i (z1), .x_o (x2), .y_o (y2), .z_o (z2)
  );

  euv_plane_rot #(.VW(VW), .T(T)) u_rot3 (
    .clk (clk), .en (en), .ctl_i (ctl3), .sin_i (s3), .cos_i (c3),
    .x_i (x2), .y_i (y2), .z_i (z2), .x_o (x3), .y_o (y3), .z_o (z3)
  );

  // clip to the coordinate range
  logic signed [VW-1:0] rv [3];
  logic [CW-1:0]        cv [3];
  logic [2:0]           clipped;

  assign rv[0] = x3;
  assign rv[1] = y3;
  assign rv[2] = z3;

  for (genvar i = 0; i < 3; i++) begin : g_clip
    always_comb begin
      if (!rv[i][VW-1] && (rv[i][VW-2:CW-1] != '0)) begin
        cv[i]      = {1'b0, {(CW-1){1'b1}}};
        clipped[i] = 1'b1;
      end else if (rv[i][VW-1] && (rv[i][VW-2:CW-1] != '1)) begin
        cv[i]      = {1'b1, {(CW-1){1'b0}}};
        clipped[i] = 1'b1;
      end else begin
        cv[i]      = rv[i][CW-1:0];
        clipped[i] = 1'b0;
      end
    end
  end

  logic [NV-1:0]  vld_r;
  logic           out_tvalid_r;
  logic [ODW-1:0] out_tdata_r;
  logic           out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      vld_r        <= {vld_r[NV-2:0], in_tvalid};
      out_tvalid_r <= vld_r[NV-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= ODW'({cv[2], cv[1], cv[0]});
      out_sat_r   <= |clipped;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_sat_r;

`ifndef NO_ASSERTIONS
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("valid flags moved during a stall");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_r[0])
    else $error("accepted request did not enter the pipeline");

  a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[SC_LAT-1] |-> (roll_s <= TRIG_ONE && roll_s >= -TRIG_ONE &&
                         roll_c <= TRIG_ONE && roll_c >= -TRIG_ONE))
    else $error("roll sine/cosine out of unit range");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_sat_r) |->
      (out_tdata_r[CW-1:CW-2] == 2'b01 || out_tdata_r[CW-1:CW-2] == 2'b10 ||
       out_tdata_r[2*CW-1:2*CW-2] == 2'b01 || out_tdata_r[2*CW-1:2*CW-2] == 2'b10 ||
       out_tdata_r[3*CW-1:3*CW-2] == 2'b01 || out_tdata_r[3*CW-1:3*CW-2] == 2'b10))
    else $error("saturation flagged without a clipped component");
`endif

endmodule
